// File: src/somr_pkg.sv
// Shared types and constants for the spiral-order matrix reader.
// Used by the controller, the datapath and the top level; no dependencies.
package somr_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_W     = 32;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int SIZE_W     = 5;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic cfg;
    } cmd_t;

endpackage

// File: src/somr_ctrl.sv
// Handshake controller for the spiral-order matrix reader.
// Depends on somr_pkg; drives the datapath through a cmd_t bundle.
module somr_ctrl
    import somr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic req_type,
    output logic out_valid,
    input  logic out_ready,
    input  logic cfg_valid,
    output logic cfg_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    // A pending register write takes precedence over a request.
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = (state_reg == ST_RESP);

    always_comb
    begin
        cmd.cfg  = cfg_valid && cfg_ready;
        cmd.load = in_valid && in_ready && !req_type;
        cmd.read = in_valid && in_ready && req_type;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.read)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/somr_dp.sv
// Datapath for the spiral-order matrix reader: size registers, load pointer,
// spiral walker and the element memory. Depends on somr_pkg.
module somr_dp
    import somr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [DATA_W-1:0] load_value,
    output logic signed [DATA_W-1:0] elem_value,
    output logic [ROW_W-1:0]        elem_row,
    output logic [COL_W-1:0]        elem_col,
    output logic                    is_last
);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(MAX_COLS);

    logic [SIZE_W-1:0] num_rows_reg, num_rows_next;
    logic [SIZE_W-1:0] num_cols_reg, num_cols_next;
    logic [ADDR_W-1:0] load_ptr_reg, load_ptr_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  bottom_reg, bottom_next;
    logic [COL_W-1:0]  left_reg, left_next;
    logic [COL_W-1:0]  right_reg, right_next;
    dir_t              dir_reg, dir_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_last_reg;

    logic [2*SIZE_W-1:0] total;
    logic [2*SIZE_W-1:0] ptr_inc;
    logic [ADDR_W:0]     addr_prod;
    logic [ADDR_W:0]     addr_sum;
    logic [ADDR_W-1:0]   rd_addr;

    // Walker step results before any restart.
    logic              walk_last;
    logic [ROW_W-1:0]  st_top, st_bottom, st_row;
    logic [COL_W-1:0]  st_left, st_right, st_col;
    dir_t              st_dir;

    assign total     = {{SIZE_W{1'b0}}, num_rows_reg} * {{SIZE_W{1'b0}}, num_cols_reg};
    assign ptr_inc   = {{(2*SIZE_W-ADDR_W){1'b0}}, load_ptr_reg} + (2*SIZE_W)'(1);
    assign addr_prod = {{(ADDR_W+1-ROW_W){1'b0}}, row_reg}
                     * {{(ADDR_W+1-SIZE_W){1'b0}}, num_cols_reg};
    assign addr_sum  = addr_prod + {{(ADDR_W+1-COL_W){1'b0}}, col_reg};
    assign rd_addr   = addr_sum[ADDR_W-1:0];

    always_comb
    begin
        walk_last = 1'b0;
        st_top    = top_reg;
        st_bottom = bottom_reg;
        st_left   = left_reg;
        st_right  = right_reg;
        st_dir    = dir_reg;
        st_row    = row_reg;
        st_col    = col_reg;
        case (dir_reg)
            DIR_RIGHT:
            begin
                if (col_reg < right_reg)
                begin
                    st_col = col_reg + COL_W'(1);
                end
                else if (top_reg >= bottom_reg)
                begin
                    walk_last = 1'b1;
                end
                else
                begin
                    st_top = top_reg + ROW_W'(1);
                    st_dir = DIR_DOWN;
                    st_row = top_reg + ROW_W'(1);
                    st_col = right_reg;
                end
            end
            DIR_DOWN:
            begin
                if (row_reg < bottom_reg)
                begin
                    st_row = row_reg + ROW_W'(1);
                end
                else if (right_reg <= left_reg)
                begin
                    walk_last = 1'b1;
                end
                else
                begin
                    st_right = right_reg - COL_W'(1);
                    st_dir   = DIR_LEFT;
                    st_row   = bottom_reg;
                    st_col   = right_reg - COL_W'(1);
                end
            end
            DIR_LEFT:
            begin
                if (col_reg > left_reg)
                begin
                    st_col = col_reg - COL_W'(1);
                end
                else if (bottom_reg <= top_reg)
                begin
                    walk_last = 1'b1;
                end
                else
                begin
                    st_bottom = bottom_reg - ROW_W'(1);
                    st_dir    = DIR_UP;
                    st_row    = bottom_reg - ROW_W'(1);
                    st_col    = left_reg;
                end
            end
            DIR_UP:
            begin
                if (row_reg > top_reg)
                begin
                    st_row = row_reg - ROW_W'(1);
                end
                else if (left_reg >= right_reg)
                begin
                    walk_last = 1'b1;
                end
                else
                begin
                    st_left = left_reg + COL_W'(1);
                    st_dir  = DIR_RIGHT;
                    st_row  = top_reg;
                    st_col  = left_reg + COL_W'(1);
                end
            end
            default:
            begin
                walk_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        load_ptr_next = load_ptr_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        dir_next      = dir_reg;
        row_next      = row_reg;
        col_next      = col_reg;

        if (cmd.cfg)
        begin
            if (cfg_index == REG_NUM_ROWS)
            begin
                num_rows_next = clamp_size(cfg_data, ROWS_MAX);
            end
            else if (cfg_index == REG_NUM_COLS)
            begin
                num_cols_next = clamp_size(cfg_data, COLS_MAX);
            end
        end

        if (cmd.read)
        begin
            top_next    = st_top;
            bottom_next = st_bottom;
            left_next   = st_left;
            right_next  = st_right;
            dir_next    = st_dir;
            row_next    = st_row;
            col_next    = st_col;
        end

        if (cmd.load)
        begin
            if (ptr_inc >= total)
            begin
                load_ptr_next = '0;
            end
            else
            begin
                load_ptr_next = ptr_inc[ADDR_W-1:0];
            end
        end

        // Restart from the top-left corner with the size that holds afterwards.
        if ((cmd.cfg && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS))
            || cmd.load || (cmd.read && walk_last))
        begin
            if (cmd.cfg)
            begin
                load_ptr_next = '0;
            end
            top_next    = '0;
            left_next   = '0;
            bottom_next = ROW_W'(num_rows_next - SIZE_W'(1));
            right_next  = COL_W'(num_cols_next - SIZE_W'(1));
            dir_next    = DIR_RIGHT;
            row_next    = '0;
            col_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= ROWS_MAX;
            num_cols_reg <= COLS_MAX;
            load_ptr_reg <= '0;
            top_reg      <= '0;
            bottom_reg   <= ROW_W'(ROWS_MAX - SIZE_W'(1));
            left_reg     <= '0;
            right_reg    <= COL_W'(COLS_MAX - SIZE_W'(1));
            dir_reg      <= DIR_RIGHT;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
            load_ptr_reg <= load_ptr_next;
            top_reg      <= top_next;
            bottom_reg   <= bottom_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            dir_reg      <= dir_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[load_ptr_reg] <= load_value;
        end
        if (cmd.read)
        begin
            rd_data_reg  <= mem[rd_addr];
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_last_reg <= walk_last;
        end
    end

    assign elem_value = rd_data_reg;
    assign elem_row   = out_row_reg;
    assign elem_col   = out_col_reg;
    assign is_last    = out_last_reg;

endmodule

// File: src/spiral_order_matrix_reader_top.sv
// A read request's result is presented in the cycle after the transaction is
// accepted and is held until taken. Loads are taken one per cycle while no
// register write is pending and no read result waits; a new read is accepted
// only after the previous result has been taken. Reset clears the control
// state, sets the size to 16 by 16 and restarts the walker; the element memory
// is not cleared. Depends on somr_pkg, somr_ctrl, somr_dp.
module spiral_order_matrix_reader_top
    import somr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic signed [DATA_W-1:0] load_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] elem_value,
    output logic [ROW_W-1:0]         elem_row,
    output logic [COL_W-1:0]         elem_col,
    output logic                     is_last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cmd_t cmd;

    somr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    somr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .load_value (load_value),
        .elem_value (elem_value),
        .elem_row   (elem_row),
        .elem_col   (elem_col),
        .is_last    (is_last)
    );

endmodule
